@@ hdl/orbc_pkg.sv @@
// Shared types and constants of the object record builder.
package orbc_pkg;

    localparam int BUF_BYTES_DEFAULT = 1024;

    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int RADDR_W    = 10;
    localparam int POS_W      = 11;
    localparam int BYTE_W     = 8;
    localparam int CAP_RESET  = 1024;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BYTE     = 3'd0,
        FUNC_WORD     = 3'd1,
        FUNC_DWORD    = 3'd2,
        FUNC_INDEX    = 3'd3,
        FUNC_SET_LEN  = 3'd4,
        FUNC_CHECKSUM = 3'd5,
        FUNC_START    = 3'd6,
        FUNC_READ     = 3'd7
    } func_t;

    // Configuration register indexes; register i sits at byte address 4*i.
    typedef enum logic {
        REG_RECORD_TYPE = 1'b0,
        REG_CAPACITY    = 1'b1
    } reg_index_t;

endpackage

@@ hdl/orbc_ram.sv @@
// Byte-wide buffer memory with one write port and one registered read port.
module orbc_ram #(
    parameter int DEPTH = orbc_pkg::BUF_BYTES_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [orbc_pkg::BYTE_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [orbc_pkg::BYTE_W-1:0] rdata
);

    logic [orbc_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // The read port always samples; the controller picks the cycle it uses.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/object_record_builder_checksum.sv @@
// Top level of the object record builder: control, configuration and result register.
//
// This block assembles the body of one object-module record in an on-chip byte buffer
// and computes the record checksum. Each input word carries one operation in s_tuser
// (append byte, word, dword or index, latch length, write checksum, start record, read
// byte) and produces exactly one result word. Items are processed one at a time: all
// operations share a single byte memory with one write and one read port, so an append
// accepts the item, stores its bytes (one to four) one after another and then hands the
// result to the output register; a refused append stores nothing. Set length and start
// pass from accepting the item straight to the output register, and a byte read waits
// for the registered memory read in between. The checksum walks the stored body through
// the read port at one byte per cycle, drains the last read and then stores the checksum
// byte. The output register lets the next item be accepted while a finished result
// waits on m_tready.
// Because only one operation is in flight, a read never overlaps a pending write to the
// same byte. The buffer is not cleared at reset; reading a byte never written returns
// an unspecified value. Registers: record_type at byte address 0, capacity at 4.
module object_record_builder_checksum #(
    parameter int BUF_BYTES = orbc_pkg::BUF_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[31:0], read_address[41:32], zero pad
    input  logic [2:0]  s_tuser,   // func[2:0]

    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[0], position[11:1], record_length[22:12],
                                   // read_data[30:23], checksum[38:31], zero pad

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W  = orbc_pkg::POS_W;
    localparam int BYTE_W = orbc_pkg::BYTE_W;
    localparam int AW     = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int CW     = $clog2(BUF_BYTES + 1);
    // Wide enough for position + 1 + size and for BUF_BYTES itself.
    localparam int WW     = ((CW > POS_W + 2) ? CW : POS_W + 2) + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_APPEND = 5'b00010,
        ST_SUM    = 5'b00100,
        ST_READ   = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

    // Control state.
    state_t                state_reg, state_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      len_reg, len_next;
    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]     rtype_reg, rtype_next;
    logic [POS_W-1:0]      cap_reg, cap_next;
    logic                  pend_reg, pend_next;

    // Operation payload.
    logic [31:0]           shift_reg, shift_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [BYTE_W-1:0]     sum_reg, sum_next;
    logic [POS_W-1:0]      idx_reg, idx_next;
    logic                  in_range_reg, in_range_next;
    logic                  status_reg, status_next;
    logic [BYTE_W-1:0]     rdata_reg, rdata_next;
    logic [BYTE_W-1:0]     csum_reg, csum_next;
    logic [39:0]           m_data_reg, m_data_next;

    // Memory port.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [BYTE_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [BYTE_W-1:0]     ram_rdata;

    // Decoded input word.
    orbc_pkg::func_t       in_func;
    logic [31:0]           in_value;
    logic [9:0]            in_raddr;
    logic                  in_accept;

    logic [WW-1:0]         eff_cap;
    logic [WW-1:0]         pos_ext;
    logic [WW-1:0]         len_ext;
    logic [WW-1:0]         raddr_ext;
    logic [WW-1:0]         idx_ext;
    logic [WW-1:0]         need;
    logic [2:0]            size;
    logic [14:0]           idx_val;
    logic [POS_W:0]        len_plus;
    logic                  issue;
    logic                  cfg_wr;

    assign in_func   = orbc_pkg::func_t'(s_tuser);
    assign in_value  = s_tdata[31:0];
    assign in_raddr  = s_tdata[41:32];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign pos_ext   = WW'(pos_reg);
    assign len_ext   = WW'(len_reg);
    assign raddr_ext = WW'(in_raddr);
    assign idx_ext   = WW'(idx_reg);
    assign eff_cap   = (WW'(cap_reg) > WW'(BUF_BYTES)) ? WW'(BUF_BYTES) : WW'(cap_reg);
    assign idx_val   = in_value[14:0];
    assign len_plus  = {1'b0, len_reg} + 1'b1;
    assign issue     = (idx_reg < len_reg);

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Configuration registers; the low address bits are not decoded.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        rtype_next = rtype_reg;
        cap_next   = cap_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                orbc_pkg::REG_RECORD_TYPE: rtype_next = pwdata[BYTE_W-1:0];
                orbc_pkg::REG_CAPACITY:    cap_next   = pwdata[POS_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            orbc_pkg::REG_RECORD_TYPE: prdata = {{(32-BYTE_W){1'b0}}, rtype_reg};
            orbc_pkg::REG_CAPACITY:    prdata = {{(32-POS_W){1'b0}}, cap_reg};
            default:                   prdata = '0;
        endcase
    end

    // Room needed by an append: position + 1 + size.
    always_comb begin
        case (in_func)
            orbc_pkg::FUNC_BYTE:  size = 3'd1;
            orbc_pkg::FUNC_DWORD: size = 3'd4;
            default:              size = 3'd2;
        endcase
        need = pos_ext + WW'(1) + WW'(size);
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        m_valid_next  = m_valid_reg;
        pend_next     = pend_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        idx_next      = idx_reg;
        in_range_next = in_range_reg;
        status_next   = status_reg;
        rdata_next    = rdata_reg;
        csum_next     = csum_reg;
        m_data_next   = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = pos_ext[AW-1:0];
        ram_wdata = shift_reg[BYTE_W-1:0];
        ram_raddr = idx_ext[AW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = raddr_ext[AW-1:0];
                if (in_accept) begin
                    status_next = 1'b0;
                    rdata_next  = '0;
                    csum_next   = '0;
                    state_next  = ST_FIN;
                    case (in_func) inside
                        orbc_pkg::FUNC_BYTE, orbc_pkg::FUNC_WORD,
                        orbc_pkg::FUNC_DWORD, orbc_pkg::FUNC_INDEX: begin
                            if (need > eff_cap) begin
                                status_next = 1'b1;
                            end else begin
                                state_next = ST_APPEND;
                                shift_next = in_value;
                                cnt_next   = size;
                                if (in_func == orbc_pkg::FUNC_INDEX) begin
                                    if (idx_val[14:7] != '0) begin
                                        // Long index: high part with the top bit set first.
                                        shift_next = {16'b0, idx_val[7:0], 1'b1, idx_val[14:8]};
                                    end else begin
                                        shift_next = {25'b0, idx_val[6:0]};
                                        cnt_next   = 3'd1;
                                    end
                                end
                            end
                        end
                        orbc_pkg::FUNC_SET_LEN: begin
                            len_next = pos_reg;
                        end
                        orbc_pkg::FUNC_CHECKSUM: begin
                            state_next = ST_SUM;
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            sum_next   = rtype_reg + len_plus[BYTE_W-1:0]
                                       + BYTE_W'(len_plus[POS_W:BYTE_W]);
                        end
                        orbc_pkg::FUNC_START: begin
                            pos_next = '0;
                            len_next = '0;
                        end
                        default: begin
                            state_next    = ST_READ;
                            in_range_next = (raddr_ext < WW'(BUF_BYTES));
                        end
                    endcase
                end
            end

            ST_APPEND: begin
                ram_we     = 1'b1;
                pos_next   = pos_reg + 1'b1;
                shift_next = {8'b0, shift_reg[31:8]};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == 3'd1) begin
                    state_next = ST_FIN;
                end
            end

            ST_SUM: begin
                // Reads are issued one per cycle; each byte is added when it returns.
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                pend_next = issue;
                if (pend_reg) begin
                    sum_next = sum_reg + ram_rdata;
                end
                if (!issue && !pend_reg) begin
                    csum_next  = BYTE_W'(0) - sum_reg;
                    ram_wdata  = BYTE_W'(0) - sum_reg;
                    ram_waddr  = len_ext[AW-1:0];
                    ram_we     = (len_ext < WW'(BUF_BYTES));
                    state_next = ST_FIN;
                end
            end

            ST_READ: begin
                rdata_next = in_range_reg ? ram_rdata : '0;
                state_next = ST_FIN;
            end

            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, csum_reg, rdata_reg, len_reg, pos_reg, status_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            rtype_reg   <= '0;
            cap_reg     <= POS_W'(orbc_pkg::CAP_RESET);
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            rtype_reg   <= rtype_next;
            cap_reg     <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        cnt_reg      <= cnt_next;
        sum_reg      <= sum_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        status_reg   <= status_next;
        rdata_reg    <= rdata_next;
        csum_reg     <= csum_next;
        m_data_reg   <= m_data_next;
    end

    orbc_ram #(
        .DEPTH (BUF_BYTES),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ tb/sv/orbc_scoreboard_pkg.sv @@
// Scoreboard class of the object record builder testbench: operation predictor and result checks.
package orbc_scoreboard_pkg;
    import orbc_pkg::*;

    typedef struct packed {
        logic              status;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  record_length;
        logic [BYTE_W-1:0] read_data;
        logic [BYTE_W-1:0] checksum;
    } record_result_t;

    class record_scoreboard;
        logic [BYTE_W-1:0] body [BUF_BYTES_DEFAULT];
        // Appends always start at zero after a start, so known bytes form a prefix.
        int                written_top;
        logic [POS_W-1:0]  write_pos;
        logic [POS_W-1:0]  body_len;
        logic [BYTE_W-1:0] rec_type;
        logic [POS_W-1:0]  capacity;
        record_result_t    expected_q[$];
        int                errors;
        int                inputs;
        int                results;
        int                refused;
        int                checksums;
        int                reads;

        function new();
            written_top = 0;
            write_pos   = '0;
            body_len    = '0;
            rec_type    = '0;
            capacity    = POS_W'(CAP_RESET);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(int idx, logic [31:0] data);
            case (idx)
                REG_RECORD_TYPE: rec_type = data[BYTE_W-1:0];
                REG_CAPACITY:    capacity = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        function void put_byte(int idx, logic [BYTE_W-1:0] b);
            body[idx] = b;
            if (idx >= written_top) written_top = idx + 1;
        endfunction

        function void store_byte(logic [BYTE_W-1:0] b);
            if (write_pos < BUF_BYTES_DEFAULT) put_byte(int'(write_pos), b);
            write_pos = write_pos + 1'b1;
        endfunction

        function void note_input(func_t op, logic [VALUE_W-1:0] value,
                                 logic [RADDR_W-1:0] addr);
            record_result_t r;
            int             size;
            int             limit;
            logic [15:0]    len_plus_one;
            logic [7:0]     acc;
            r      = '0;
            limit  = (capacity > BUF_BYTES_DEFAULT) ? BUF_BYTES_DEFAULT : int'(capacity);
            inputs++;
            case (op)
                FUNC_BYTE, FUNC_WORD, FUNC_DWORD, FUNC_INDEX: begin
                    size = (op == FUNC_BYTE) ? 1 : (op == FUNC_DWORD) ? 4 : 2;
                    if (int'(write_pos) + 1 + size > limit) begin
                        r.status = 1'b1;
                        refused++;
                    end else if (op == FUNC_INDEX) begin
                        if (value[14:0] >= 15'h80) begin
                            store_byte({1'b1, value[14:8]});
                            store_byte(value[7:0]);
                        end else begin
                            store_byte(value[7:0]);
                        end
                    end else begin
                        for (int i = 0; i < size; i++) store_byte(value[8*i +: 8]);
                    end
                end
                FUNC_SET_LEN: begin
                    body_len = write_pos;
                end
                FUNC_CHECKSUM: begin
                    len_plus_one = 16'(body_len) + 16'd1;
                    acc = rec_type + len_plus_one[7:0] + len_plus_one[15:8];
                    for (int i = 0; i < int'(body_len) && i < BUF_BYTES_DEFAULT; i++)
                        acc += body[i];
                    r.checksum = 8'h00 - acc;
                    if (body_len < BUF_BYTES_DEFAULT) put_byte(int'(body_len), r.checksum);
                    checksums++;
                end
                FUNC_START: begin
                    write_pos = '0;
                    body_len  = '0;
                end
                default: begin
                    r.read_data = body[addr];
                    reads++;
                end
            endcase
            r.position      = write_pos;
            r.record_length = body_len;
            expected_q.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Result word: status[0], position[11:1], record_length[22:12],
        // read_data[30:23], checksum[38:31], zero pad[39].
        function void check_result(logic [39:0] word);
            record_result_t exp_r;
            results++;
            if (expected_q.size() == 0) begin
                $error("result word 0x%010h arrived with no operation outstanding", word);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare("status", 32'(exp_r.status), 32'(word[0]));
            compare("position", 32'(exp_r.position), 32'(word[11:1]));
            compare("record_length", 32'(exp_r.record_length), 32'(word[22:12]));
            compare("read_data", 32'(exp_r.read_data), 32'(word[30:23]));
            compare("checksum", 32'(exp_r.checksum), 32'(word[38:31]));
            compare("pad", 32'd0, 32'(word[39]));
        endfunction
    endclass

endpackage

@@ tb/sv/tb.sv @@
// Top of the object record builder testbench: clock, reset, stream and register drivers.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orbc_pkg::*;
    import orbc_scoreboard_pkg::*;

    // The slowest operation is a checksum over a body that fills the buffer, and the result
    // may then wait out a receiver stall. The watchdog only counts cycles in which no word
    // moves on either side, so this bound is several times that worst case.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles after the last result before a register write or the verdict.
    localparam int SETTLE_CYCLES  = 12;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // value[31:0], read_address[41:32], zero pad
    logic [2:0]  s_tuser  = '0;   // func[2:0]

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // status[0], position[11:1], record_length[22:12],
                                  // read_data[30:23], checksum[38:31], zero pad

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    record_scoreboard sb;

    int burst_left      = 0;
    int stall_left      = 0;
    int stall_mode_left = 0;
    bit stalling        = 1'b0;
    int idle_cycles     = 0;
    int settings        = 0;

    object_record_builder_checksum dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side. Words are checked as they are taken. The ready pattern alternates
    // between stretches that never stall and stretches with short random stalls, so
    // back-pressure lands on every phase of the block's work.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (stall_mode_left == 0) begin
            stalling        = ($urandom_range(2, 0) != 0);
            stall_mode_left = $urandom_range(200, 20);
        end else begin
            stall_mode_left--;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (stalling && $urandom_range(2, 0) == 0) stall_left = $urandom_range(6, 1);
        end
    end

    // A hang shows up as a long run of cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Register write: a setup phase, then an access phase that completes on pready.
    task automatic reg_write(int idx, logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * idx);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Sends one operation word. The sender works in bursts; between bursts it may drop
    // valid for a random gap. When no gap is due, valid simply stays high and only the
    // payload changes, so valid is never lowered and raised in the same step.
    task automatic send_op(func_t op, logic [VALUE_W-1:0] value, logic [RADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(2, 0) != 0) gap = $urandom_range(7, 1);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, addr, value};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, value, addr);
    endtask

    // Stops sending and waits until every expected result word has been taken.
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Registers change only with the block idle, so every setting starts from a drain.
    task automatic configure(logic [7:0] rtype, logic [POS_W-1:0] cap);
        drain();
        reg_write(REG_RECORD_TYPE, 32'(rtype));
        reg_write(REG_CAPACITY, 32'(cap));
        settings++;
    endtask

    // Reads only bytes that hold known data; the buffer is not cleared at reset.
    task automatic read_known();
        logic [RADDR_W-1:0] a;
        if (sb.written_top == 0) return;
        a = RADDR_W'($urandom_range(sb.written_top - 1, 0));
        send_op(FUNC_READ, $urandom, a);
    endtask

    // One random append. Half the indexes are short ones, below 0x80 in the low 15 bits.
    task automatic random_append(int dword_pct);
        func_t              op;
        logic [VALUE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(99, 0) < dword_pct) op = FUNC_DWORD;
        else op = func_t'(3'($urandom_range(3, 0)));
        if (op == FUNC_INDEX && $urandom_range(1, 0) == 1) v[14:7] = '0;
        send_op(op, v, RADDR_W'($urandom));
    endtask

    // A well-formed record: start, appends, latch the length, sometimes one append past
    // the latched length (which the checksum then overwrites), checksum, and read-back
    // of the checksum byte plus a few random known bytes.
    task automatic build_record(int n);
        send_op(FUNC_START, $urandom, RADDR_W'($urandom));
        repeat (n) random_append(10);
        send_op(FUNC_SET_LEN, $urandom, RADDR_W'($urandom));
        if ($urandom_range(3, 0) == 0) random_append(10);
        send_op(FUNC_CHECKSUM, $urandom, RADDR_W'($urandom));
        send_op(FUNC_READ, $urandom, RADDR_W'(sb.body_len));
        repeat ($urandom_range(2, 0)) read_known();
    endtask

    // Any operation in any order; every one except a read is legal at any time.
    task automatic noise_op();
        func_t op;
        op = func_t'(3'($urandom));
        if (op == FUNC_READ) read_known();
        else if (op <= FUNC_INDEX) random_append(0);
        else send_op(op, $urandom, RADDR_W'($urandom));
    endtask

    task automatic random_phase(logic [7:0] rtype, logic [POS_W-1:0] cap, int n);
        int first;
        configure(rtype, cap);
        first = sb.inputs;
        while (sb.inputs - first < n) begin
            if ($urandom_range(4, 0) == 0) noise_op();
            else build_record($urandom_range(14, 0));
        end
    endtask

    initial begin
        logic [POS_W-1:0] caps [5];
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: field extremes, every operation, both index encodings,
        // a checksum over an empty body and one over a body with a trailing append.
        configure(8'hFF, POS_W'(CAP_RESET));
        send_op(FUNC_CHECKSUM, 32'h0000_0000, '0);
        send_op(FUNC_READ, 32'hFFFF_FFFF, '0);
        send_op(FUNC_START, 32'hFFFF_FFFF, '1);
        send_op(FUNC_BYTE, 32'hFFFF_FFFF, '1);
        send_op(FUNC_BYTE, 32'h0000_0000, '0);
        send_op(FUNC_WORD, 32'h0000_FFFF, '0);
        send_op(FUNC_WORD, 32'hFFFF_0000, '1);
        send_op(FUNC_DWORD, 32'hFFFF_FFFF, '0);
        send_op(FUNC_DWORD, 32'h0000_0000, '1);
        send_op(FUNC_INDEX, 32'h0000_007F, '0);   // largest one-byte index
        send_op(FUNC_INDEX, 32'h0000_0080, '0);   // smallest two-byte index
        send_op(FUNC_INDEX, 32'h0000_7FFF, '0);
        send_op(FUNC_INDEX, 32'hFFFF_8000, '0);   // bits above 14 are ignored
        send_op(FUNC_SET_LEN, 32'hFFFF_FFFF, '1);
        send_op(FUNC_CHECKSUM, 32'hFFFF_FFFF, '1);
        send_op(FUNC_READ, 32'h0000_0000, RADDR_W'(sb.body_len));
        send_op(FUNC_READ, 32'h0000_0000, 10'd1);
        send_op(FUNC_BYTE, 32'h0000_005A, '0);
        send_op(FUNC_CHECKSUM, 32'h0000_0000, '0);
        send_op(FUNC_READ, 32'h0000_0000, RADDR_W'(sb.body_len));
        send_op(FUNC_START, 32'h0000_0000, '0);
        send_op(FUNC_CHECKSUM, 32'h0000_0000, '0);
        send_op(FUNC_READ, 32'h0000_0000, '0);

        // No buffer at all: every append is refused, the rest still answer.
        configure(8'h00, '0);
        send_op(FUNC_BYTE, $urandom, '0);
        send_op(FUNC_WORD, $urandom, '0);
        send_op(FUNC_DWORD, $urandom, '0);
        send_op(FUNC_INDEX, 32'h0000_0011, '0);
        send_op(FUNC_INDEX, 32'h0000_4321, '0);
        send_op(FUNC_SET_LEN, $urandom, '0);
        send_op(FUNC_CHECKSUM, $urandom, '0);
        send_op(FUNC_READ, $urandom, '0);
        send_op(FUNC_START, $urandom, '0);

        // A capacity above the buffer size acts as the full buffer. Fill it up to the byte
        // before the last, run into the refusal at the very end, then checksum the full body;
        // the checksum lands in the last buffer byte and is read back.
        configure(8'($urandom), '1);
        send_op(FUNC_START, $urandom, '0);
        while (sb.write_pos < POS_W'(BUF_BYTES_DEFAULT - 1))
            random_append((sb.write_pos > 11'd1015) ? 0 : 85);
        send_op(FUNC_BYTE, $urandom, '0);
        send_op(FUNC_SET_LEN, $urandom, '0);
        send_op(FUNC_CHECKSUM, $urandom, '0);
        send_op(FUNC_READ, $urandom, '1);
        repeat (4) read_known();

        // Random records under tiny, small, medium and full capacities.
        caps[0] = 11'd1;
        caps[1] = 11'd2;
        caps[2] = POS_W'($urandom_range(40, 3));
        caps[3] = POS_W'($urandom_range(600, 41));
        caps[4] = POS_W'(CAP_RESET);
        foreach (caps[i]) random_phase(8'($urandom), caps[i], 45);

        drain();
        $display("Ran %0d operations under %0d settings: %0d refused, %0d checksums, %0d reads.",
                 sb.inputs, settings, sb.refused, sb.checksums, sb.reads);
        $display("Compared %0d result words; known buffer contents reached %0d bytes.",
                 sb.results, sb.written_top);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
